>>> src/window_median_select_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros used by the median select checker
// ---------------------------------------------------------------------------
`ifndef WINDOW_MEDIAN_SELECT_MACROS_SVH
`define WINDOW_MEDIAN_SELECT_MACROS_SVH

// same-cycle implication, off while in reset
`define WMS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wms assertion failed");

// next-cycle implication, off while in reset
`define WMS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wms assertion failed");

`endif

>>> src/wms_pkg.sv
// ---------------------------------------------------------------------------
// wms_pkg
// Types and constants of the window median select block.
// ---------------------------------------------------------------------------
package wms_pkg;

    localparam int MAX_WINDOW = 25;
    localparam int SAMPLE_W   = 8;
    localparam int COUNT_W    = $clog2(MAX_WINDOW + 1);

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                last;
    } sample_in_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] median;
        logic                overflow;
    } result_t;

    // value and shift flag handed from one cell to the next
    typedef struct packed {
        logic [SAMPLE_W-1:0] value;
        logic                shift;
    } cell_link_t;

    // per-cell control from the top level
    typedef struct packed {
        logic occupied;
        logic tail;
        logic pick_hi;
        logic pick_lo;
    } cell_ctrl_t;

    typedef enum logic {
        ST_COLLECT,
        ST_EMIT
    } state_t;

endpackage

>>> src/window_median_select.sv
// ---------------------------------------------------------------------------
// window_median_select
// Median of one filter window of 8-bit samples, kept sorted on arrival.
// ---------------------------------------------------------------------------
// Samples go in on start/item, one transfer per cycle while busy is low.
// Each transfer is inserted into a chain of MAX_WINDOW compare-and-shift
// cells, so the chain stays in ascending order.
// A transfer with item.last set closes the window. busy is then high for one
// cycle while the middle pair is picked from the chain and averaged; the
// result shows on result with done high for one cycle in the following
// cycle. New samples are taken again in that same cycle.
// Throughput: one sample per cycle, none while busy is high between windows.
// Samples beyond MAX_WINDOW are dropped and result.overflow is set for that
// window; a dropped last sample still closes it.
// Reset clears the fill count, the drop flag and the output strobe; cell
// contents are left as they are and are never read before being written.
// There is no back-pressure on the result side.
// ---------------------------------------------------------------------------
module window_median_select
    import wms_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  sample_in_t item,
    output logic       busy,
    output logic       done,
    output result_t    result
);

    state_t               state_reg;
    state_t               state_next;
    logic [COUNT_W-1:0]   count_reg;
    logic [COUNT_W-1:0]   count_next;
    logic                 dropped_reg;
    logic                 dropped_next;
    logic                 done_reg;
    logic                 done_next;
    result_t              result_reg;
    result_t              result_next;

    logic                 accept;
    logic                 full;
    logic                 insert_en;
    logic [COUNT_W-1:0]   half;
    logic [COUNT_W-1:0]   lo_idx;
    logic [SAMPLE_W:0]    pair_sum;
    logic [SAMPLE_W-1:0]  mid_hi;
    logic [SAMPLE_W-1:0]  mid_lo;

    cell_ctrl_t           ctrl   [MAX_WINDOW];
    cell_link_t           links  [MAX_WINDOW];
    cell_link_t           prevs  [MAX_WINDOW];
    logic [SAMPLE_W-1:0]  taps_hi[MAX_WINDOW];
    logic [SAMPLE_W-1:0]  taps_lo[MAX_WINDOW];

    assign busy      = (state_reg == ST_EMIT);
    assign accept    = start && !busy;
    assign full      = (count_reg == COUNT_W'(MAX_WINDOW));
    assign insert_en = accept && !full;

    // odd count: both picks on the middle cell
    assign half   = count_reg >> 1;
    assign lo_idx = count_reg[0] ? half : (half - COUNT_W'(1));

    genvar i;
    generate
        for (i = 0; i < MAX_WINDOW; i++)
        begin : g_cell
            assign ctrl[i].occupied = (count_reg > COUNT_W'(i));
            assign ctrl[i].tail     = (count_reg == COUNT_W'(i));
            assign ctrl[i].pick_hi  = (half == COUNT_W'(i));
            assign ctrl[i].pick_lo  = (lo_idx == COUNT_W'(i));

            if (i == 0)
            begin : g_head
                assign prevs[i] = '0;
            end
            else
            begin : g_body
                assign prevs[i] = links[i-1];
            end

            wms_cell u_cell (
                .clk       (clk),
                .insert_en (insert_en),
                .sample    (item.sample),
                .ctrl      (ctrl[i]),
                .prev      (prevs[i]),
                .link      (links[i]),
                .tap_hi    (taps_hi[i]),
                .tap_lo    (taps_lo[i])
            );
        end
    endgenerate

    // at most one cell drives each tap, the rest give zero
    always_comb
    begin
        mid_hi = '0;
        mid_lo = '0;
        for (int k = 0; k < MAX_WINDOW; k++)
        begin
            mid_hi = mid_hi | taps_hi[k];
            mid_lo = mid_lo | taps_lo[k];
        end
    end

    assign pair_sum = {1'b0, mid_hi} + {1'b0, mid_lo};

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        dropped_next = dropped_reg;
        done_next    = 1'b0;
        result_next  = result_reg;
        unique case (state_reg)
            ST_COLLECT:
            begin
                if (accept)
                begin
                    if (full)
                    begin
                        dropped_next = 1'b1;
                    end
                    else
                    begin
                        count_next = count_reg + COUNT_W'(1);
                    end
                    if (item.last)
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                result_next.median   = pair_sum[SAMPLE_W:1];
                result_next.overflow = dropped_reg;
                done_next            = 1'b1;
                count_next           = '0;
                dropped_next         = 1'b0;
                state_next           = ST_COLLECT;
            end
            default:
            begin
                state_next = ST_COLLECT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_COLLECT;
            count_reg   <= '0;
            dropped_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

>>> src/wms_cell.sv
// ---------------------------------------------------------------------------
// wms_cell
// One slot of the sorted insertion chain: holds a sample, compares it with
// the incoming one and either keeps it, takes the new sample or takes the
// value of its lower neighbour.
// ---------------------------------------------------------------------------
module wms_cell
    import wms_pkg::*;
(
    input  logic                clk,
    input  logic                insert_en,
    input  logic [SAMPLE_W-1:0] sample,
    input  cell_ctrl_t          ctrl,
    input  cell_link_t          prev,
    output cell_link_t          link,
    output logic [SAMPLE_W-1:0] tap_hi,
    output logic [SAMPLE_W-1:0] tap_lo
);

    logic [SAMPLE_W-1:0] value_reg;
    logic [SAMPLE_W-1:0] value_next;
    logic                greater;

    assign greater = ctrl.occupied && (value_reg > sample);

    always_comb
    begin
        value_next = value_reg;
        if (insert_en && (greater || ctrl.tail))
        begin
            value_next = prev.shift ? prev.value : sample;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign link.value = value_reg;
    assign link.shift = greater;
    assign tap_hi     = ctrl.pick_hi ? value_reg : '0;
    assign tap_lo     = ctrl.pick_lo ? value_reg : '0;

endmodule

>>> src/wms_checker.sv
// ---------------------------------------------------------------------------
// wms_checker
// Port-level checks on the window median select block.
// ---------------------------------------------------------------------------
`include "window_median_select_macros.svh"

module wms_checker
    import wms_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input sample_in_t item,
    input logic       busy,
    input logic       done,
    input result_t    result
);

    // a closing transfer always leads to the emit cycle
    `WMS_ASSERT_NEXT(a_last_sets_busy, start && !busy && item.last, busy)
    // emit phase lasts one cycle and is always followed by a result
    `WMS_ASSERT_NEXT(a_busy_one_cycle, busy, !busy && done)
    // a result only ever follows the emit cycle
    `WMS_ASSERT_NOW(a_done_after_busy, done, $past(busy))

endmodule

bind window_median_select wms_checker u_wms_checker (.*);
